/* sv/potential_field_velocity_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the potential field velocity block
// Immediate-consequence and next-cycle property forms, reporting by $error.
// ----------------------------------------------------------------------------
`ifndef POTENTIAL_FIELD_VELOCITY_TOP_ASSERT_SVH
`define POTENTIAL_FIELD_VELOCITY_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/pfv_pkg.sv */
// ----------------------------------------------------------------------------
// pfv_pkg
// Types, constants, saturation and magnitude helpers of the potential field velocity block.
// ----------------------------------------------------------------------------
package pfv_pkg;

   localparam int MAX_OBSTACLES_DEF = 8;
   localparam int FRAC_BITS_DEF     = 16;
   localparam int CSR_ADDR_W        = 5;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_ATTRACT_GAIN     = 3'd0;
   localparam logic [2:0] REG_REPULSE_GAIN     = 3'd1;
   localparam logic [2:0] REG_INFLUENCE_RADIUS = 3'd2;
   localparam logic [2:0] REG_SPEED_LIMIT      = 3'd3;
   localparam logic [2:0] REG_TARGET_X         = 3'd4;
   localparam logic [2:0] REG_TARGET_Y         = 3'd5;
   localparam logic [2:0] REG_TARGET_Z         = 3'd6;
   localparam logic [2:0] REG_ACTIVE_OBSTACLES = 3'd7;

   // Reset values of the registers.
   localparam logic [30:0]        RST_ATTRACT_GAIN     = 31'd98304;
   localparam logic [30:0]        RST_REPULSE_GAIN     = 31'd327680;
   localparam logic [30:0]        RST_INFLUENCE_RADIUS = 31'd196608;
   localparam logic [30:0]        RST_SPEED_LIMIT      = 31'd131072;
   localparam logic signed [31:0] RST_TARGET_X         = 32'sd655360;
   localparam logic signed [31:0] RST_TARGET_Y         = 32'sd655360;
   localparam logic signed [31:0] RST_TARGET_Z         = 32'sd327680;
   localparam logic [3:0]         RST_ACTIVE_OBSTACLES = 4'd0;

   // Item function codes.
   localparam logic FUNC_POSITION = 1'b0;
   localparam logic FUNC_OBSTACLE = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LOOP,
      S_DIFF,
      S_SQMUL,
      S_SQACC,
      S_SQRT,
      S_DIV,
      S_DCHK,
      S_INVR,
      S_MAGMUL,
      S_MAG,
      S_M1,
      S_M2,
      S_U,
      S_REPMUL,
      S_REPADD,
      S_ATTMUL,
      S_ATTADD,
      S_VSQMUL,
      S_VSQACC,
      S_NCHK,
      S_CLMUL,
      S_CLDIV,
      S_CLQ,
      S_OUT
   } pfv_state_type;

   // Clamp a wide signed value to the 32 bit signed range.
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -66'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Clamp a non-negative value to the 31 bit positive range.
   function automatic logic [30:0] satpos(input logic [63:0] v);
      logic [30:0] r;
      if (v > 64'h7FFF_FFFF) begin
         r = '1;
      end else begin
         r = v[30:0];
      end
      return r;
   endfunction

   // Magnitude of a 32 bit signed value.
   function automatic logic [32:0] absval(input logic signed [31:0] v);
      logic signed [32:0] e;
      e = 33'(v);
      return v[31] ? 33'(-e) : 33'(e);
   endfunction

endpackage

/* sv/potential_field_velocity_top.sv */
// ----------------------------------------------------------------------------
// potential_field_velocity_top
// Potential field velocity command: attraction to a target, repulsion from up
// to MAX_OBSTACLES stored obstacles, and a speed limit, in signed fixed point.
// ----------------------------------------------------------------------------
// An obstacle write completes at its accept edge; busy never rises for it.
// A position word takes longer for each obstacle out of range, longer still
// for each obstacle in range, and longer again when the speed is limited. The
// one-bit-per-cycle divider and square-root unit set this.
// One result strobe per position word; the receiver cannot stall it.
// Synchronous reset returns the sequencer to idle and the configuration registers to defaults.

module potential_field_velocity_top #(
   parameter int MAX_OBSTACLES = pfv_pkg::MAX_OBSTACLES_DEF,
   parameter int FRAC_BITS     = pfv_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_func,
   input  logic signed [31:0]                req_coord_x,
   input  logic signed [31:0]                req_coord_y,
   input  logic signed [31:0]                req_coord_z,
   input  logic [2:0]                        req_obstacle_slot,
   output logic                              rsp_valid,
   output logic signed [31:0]                rsp_vel_x,
   output logic signed [31:0]                rsp_vel_y,
   output logic signed [31:0]                rsp_vel_z,
   output logic                              rsp_speed_clipped,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pfv_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   `include "potential_field_velocity_top_assert.svh"

   // Index width of the obstacle store and width of the obstacle counter,
   // which must also hold the obstacle count itself.
   localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);

   // One squared in the fixed-point format, and the minimum distance of 0.01.
   localparam logic [63:0] ONE_SQ   = 64'(1) << (2 * FRAC_BITS);
   localparam logic [31:0] MIN_DIST = 32'(((64'(1) << FRAC_BITS) + 64'd50) / 64'd100);

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [30:0]        attract_ff;
   logic [30:0]        repulse_ff;
   logic [30:0]        radius_ff;
   logic [30:0]        limit_ff;
   logic signed [31:0] target_ff [3];
   logic [3:0]         active_ff;
   logic               csr_write;

   // The port never waits, so a write lands at the end of its access cycle.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         attract_ff   <= pfv_pkg::RST_ATTRACT_GAIN;
         repulse_ff   <= pfv_pkg::RST_REPULSE_GAIN;
         radius_ff    <= pfv_pkg::RST_INFLUENCE_RADIUS;
         limit_ff     <= pfv_pkg::RST_SPEED_LIMIT;
         target_ff[0] <= pfv_pkg::RST_TARGET_X;
         target_ff[1] <= pfv_pkg::RST_TARGET_Y;
         target_ff[2] <= pfv_pkg::RST_TARGET_Z;
         active_ff    <= pfv_pkg::RST_ACTIVE_OBSTACLES;
      end else if (csr_write) begin
         case (paddr[4:2])
            pfv_pkg::REG_ATTRACT_GAIN:     attract_ff   <= pwdata[30:0];
            pfv_pkg::REG_REPULSE_GAIN:     repulse_ff   <= pwdata[30:0];
            pfv_pkg::REG_INFLUENCE_RADIUS: radius_ff    <= pwdata[30:0];
            pfv_pkg::REG_SPEED_LIMIT:      limit_ff     <= pwdata[30:0];
            pfv_pkg::REG_TARGET_X:         target_ff[0] <= pwdata;
            pfv_pkg::REG_TARGET_Y:         target_ff[1] <= pwdata;
            pfv_pkg::REG_TARGET_Z:         target_ff[2] <= pwdata;
            pfv_pkg::REG_ACTIVE_OBSTACLES: active_ff    <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         pfv_pkg::REG_ATTRACT_GAIN:     prdata = {1'b0, attract_ff};
         pfv_pkg::REG_REPULSE_GAIN:     prdata = {1'b0, repulse_ff};
         pfv_pkg::REG_INFLUENCE_RADIUS: prdata = {1'b0, radius_ff};
         pfv_pkg::REG_SPEED_LIMIT:      prdata = {1'b0, limit_ff};
         pfv_pkg::REG_TARGET_X:         prdata = target_ff[0];
         pfv_pkg::REG_TARGET_Y:         prdata = target_ff[1];
         pfv_pkg::REG_TARGET_Z:         prdata = target_ff[2];
         pfv_pkg::REG_ACTIVE_OBSTACLES: prdata = {28'd0, active_ff};
         default:                       prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer and datapath registers
   // ------------------------------------------------------------------------
   pfv_pkg::pfv_state_type state_ff, state_in;
   pfv_pkg::pfv_state_type ret_ff, ret_in;

   logic [5:0]         cnt_ff, cnt_in;       // divider and square-root step count
   logic [1:0]         idx_ff, idx_in;       // axis being worked on
   logic [CNT_W-1:0]   k_ff, k_in;           // obstacle being worked on
   logic [CNT_W-1:0]   n_ff, n_in;           // obstacles to visit
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   logic signed [31:0] diff_ff [3];
   logic signed [31:0] diff_in [3];
   logic signed [31:0] rep_ff [3];
   logic signed [31:0] rep_in [3];
   logic signed [31:0] vel_ff [3];
   logic signed [31:0] vel_in [3];
   logic               clip_ff, clip_in;
   logic [63:0]        acc_ff, acc_in;       // sum of squares
   logic [63:0]        sq_x_ff, sq_x_in;
   logic [63:0]        sq_r_ff, sq_r_in;
   logic [63:0]        sq_bit_ff, sq_bit_in;
   logic [63:0]        div_num_ff, div_num_in; // dividend shifting out, quotient in
   logic [31:0]        div_rem_ff, div_rem_in;
   logic [31:0]        div_den_ff, div_den_in;
   logic [31:0]        d_ff, d_in;
   logic [31:0]        invd_ff, invd_in;
   logic [30:0]        m_ff, m_in;           // repulsion magnitude, later over d^2
   logic signed [32:0] u_ff, u_in;           // unit vector component
   logic signed [65:0] prod_ff, prod_in;     // shared multiplier output

   // Obstacle store and its registered read port.
   logic signed [31:0] obs_x_mem [MAX_OBSTACLES];
   logic signed [31:0] obs_y_mem [MAX_OBSTACLES];
   logic signed [31:0] obs_z_mem [MAX_OBSTACLES];
   logic signed [31:0] obs_rd_ff [3];

   // ------------------------------------------------------------------------
   // Combinational helpers shared by the state and datapath blocks
   // ------------------------------------------------------------------------
   logic               accept;
   logic               last_axis;
   logic               more_obs;
   logic               obs_near;
   logic               need_clip;
   logic [IDX_W-1:0]   k_idx;
   logic [1:0]         next_axis;
   logic signed [32:0] mul_a, mul_b;
   logic               div_load;
   logic [63:0]        div_num_load;
   logic [31:0]        div_den_load;
   logic [30:0]        mag_sat;
   logic [30:0]        quo_sat;
   logic [32:0]        rem_sh;
   logic               rem_ge;
   logic [63:0]        sq_rb;
   logic signed [31:0] err_sel;
   logic [6:0]         act_ext;

   assign accept    = start && !busy;
   assign last_axis = (idx_ff == 2'd2);
   assign next_axis = last_axis ? 2'd2 : idx_ff + 2'd1;
   assign more_obs  = (k_ff < n_ff);
   assign k_idx     = k_ff[IDX_W-1:0];
   // An obstacle acts only strictly between the minimum distance and the radius.
   assign obs_near  = (sq_r_ff[31:0] > MIN_DIST) && (sq_r_ff[31:0] < {1'b0, radius_ff});
   assign need_clip = (sq_r_ff > 64'(limit_ff));
   assign mag_sat   = pfv_pkg::satpos(prod_ff[63:0] >> FRAC_BITS);
   assign quo_sat   = pfv_pkg::satpos(div_num_ff);
   assign act_ext   = 7'(active_ff);
   assign err_sel   = pfv_pkg::sat32(66'(target_ff[idx_ff]) - 66'(pos_ff[idx_ff]));

   // One restoring division step and one square-root step per cycle.
   assign rem_sh = {div_rem_ff, div_num_ff[63]};
   assign rem_ge = (rem_sh >= {1'b0, div_den_ff});
   assign sq_rb  = sq_r_ff + sq_bit_ff;

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         pfv_pkg::S_IDLE: begin
            if (accept && req_func == pfv_pkg::FUNC_POSITION) begin
               state_in = pfv_pkg::S_LOOP;
            end
         end
         pfv_pkg::S_LOOP:  state_in = more_obs ? pfv_pkg::S_DIFF : pfv_pkg::S_ATTMUL;
         pfv_pkg::S_DIFF:  state_in = pfv_pkg::S_SQMUL;
         pfv_pkg::S_SQMUL: state_in = pfv_pkg::S_SQACC;
         pfv_pkg::S_SQACC: begin
            if (last_axis) begin
               state_in = pfv_pkg::S_SQRT;
               ret_in   = pfv_pkg::S_DCHK;
            end else begin
               state_in = pfv_pkg::S_SQMUL;
            end
         end
         pfv_pkg::S_SQRT: begin
            if (cnt_ff == 6'd31) begin
               state_in = ret_ff;
            end
         end
         pfv_pkg::S_DIV: begin
            if (cnt_ff == 6'd63) begin
               state_in = ret_ff;
            end
         end
         pfv_pkg::S_DCHK: begin
            if (obs_near) begin
               state_in = pfv_pkg::S_DIV;
               ret_in   = pfv_pkg::S_INVR;
            end else begin
               state_in = pfv_pkg::S_LOOP;
            end
         end
         pfv_pkg::S_INVR: begin
            state_in = pfv_pkg::S_DIV;
            ret_in   = pfv_pkg::S_MAGMUL;
         end
         pfv_pkg::S_MAGMUL: state_in = pfv_pkg::S_MAG;
         pfv_pkg::S_MAG: begin
            state_in = pfv_pkg::S_DIV;
            ret_in   = pfv_pkg::S_M1;
         end
         pfv_pkg::S_M1: begin
            state_in = pfv_pkg::S_DIV;
            ret_in   = pfv_pkg::S_M2;
         end
         pfv_pkg::S_M2: begin
            state_in = pfv_pkg::S_DIV;
            ret_in   = pfv_pkg::S_U;
         end
         pfv_pkg::S_U:      state_in = pfv_pkg::S_REPMUL;
         pfv_pkg::S_REPMUL: state_in = pfv_pkg::S_REPADD;
         pfv_pkg::S_REPADD: begin
            if (last_axis) begin
               state_in = pfv_pkg::S_LOOP;
            end else begin
               state_in = pfv_pkg::S_DIV;
               ret_in   = pfv_pkg::S_U;
            end
         end
         pfv_pkg::S_ATTMUL: state_in = pfv_pkg::S_ATTADD;
         pfv_pkg::S_ATTADD: state_in = last_axis ? pfv_pkg::S_VSQMUL : pfv_pkg::S_ATTMUL;
         pfv_pkg::S_VSQMUL: state_in = pfv_pkg::S_VSQACC;
         pfv_pkg::S_VSQACC: begin
            if (last_axis) begin
               state_in = pfv_pkg::S_SQRT;
               ret_in   = pfv_pkg::S_NCHK;
            end else begin
               state_in = pfv_pkg::S_VSQMUL;
            end
         end
         pfv_pkg::S_NCHK:  state_in = need_clip ? pfv_pkg::S_CLMUL : pfv_pkg::S_OUT;
         pfv_pkg::S_CLMUL: state_in = pfv_pkg::S_CLDIV;
         pfv_pkg::S_CLDIV: begin
            state_in = pfv_pkg::S_DIV;
            ret_in   = pfv_pkg::S_CLQ;
         end
         pfv_pkg::S_CLQ: state_in = last_axis ? pfv_pkg::S_OUT : pfv_pkg::S_CLMUL;
         pfv_pkg::S_OUT: state_in = pfv_pkg::S_IDLE;
         default:        state_in = pfv_pkg::S_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Outputs of the sequencer: handshake, multiplier operands, divider loads
   // ------------------------------------------------------------------------
   always_comb begin
      busy         = (state_ff != pfv_pkg::S_IDLE);
      rsp_valid    = (state_ff == pfv_pkg::S_OUT);
      mul_a        = '0;
      mul_b        = '0;
      div_load     = 1'b0;
      div_num_load = ONE_SQ;
      div_den_load = d_ff;
      case (state_ff)
         pfv_pkg::S_SQMUL: begin
            mul_a = 33'(diff_ff[idx_ff]);
            mul_b = 33'(diff_ff[idx_ff]);
         end
         pfv_pkg::S_MAGMUL: begin
            // The quotient just finished is one over the radius.
            mul_a = $signed({1'b0, invd_ff - div_num_ff[31:0]});
            mul_b = $signed({2'b00, repulse_ff});
         end
         pfv_pkg::S_REPMUL: begin
            mul_a = $signed({2'b00, m_ff});
            mul_b = u_ff;
         end
         pfv_pkg::S_ATTMUL: begin
            mul_a = 33'(err_sel);
            mul_b = $signed({2'b00, attract_ff});
         end
         pfv_pkg::S_VSQMUL: begin
            mul_a = 33'(vel_ff[idx_ff]);
            mul_b = 33'(vel_ff[idx_ff]);
         end
         pfv_pkg::S_CLMUL: begin
            mul_a = $signed(pfv_pkg::absval(vel_ff[idx_ff]));
            mul_b = $signed({2'b00, limit_ff});
         end
         pfv_pkg::S_DCHK: begin
            div_load     = obs_near;
            div_den_load = sq_r_ff[31:0];
         end
         pfv_pkg::S_INVR: begin
            div_load     = 1'b1;
            div_den_load = {1'b0, radius_ff};
         end
         pfv_pkg::S_MAG: begin
            div_load     = 1'b1;
            div_num_load = 64'(mag_sat) << FRAC_BITS;
         end
         pfv_pkg::S_M1: begin
            div_load     = 1'b1;
            div_num_load = 64'(quo_sat) << FRAC_BITS;
         end
         pfv_pkg::S_M2: begin
            div_load     = 1'b1;
            div_num_load = 64'(pfv_pkg::absval(diff_ff[0])) << FRAC_BITS;
         end
         pfv_pkg::S_REPADD: begin
            div_load     = !last_axis;
            div_num_load = 64'(pfv_pkg::absval(diff_ff[next_axis])) << FRAC_BITS;
         end
         pfv_pkg::S_CLDIV: begin
            div_load     = 1'b1;
            div_num_load = prod_ff[63:0];
            div_den_load = sq_r_ff[31:0];
         end
         default: ;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // ------------------------------------------------------------------------
   // Datapath next values
   // ------------------------------------------------------------------------
   always_comb begin
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      k_in       = k_ff;
      n_in       = n_ff;
      pos_in     = pos_ff;
      diff_in    = diff_ff;
      rep_in     = rep_ff;
      vel_in     = vel_ff;
      clip_in    = clip_ff;
      acc_in     = acc_ff;
      sq_x_in    = sq_x_ff;
      sq_r_in    = sq_r_ff;
      sq_bit_in  = sq_bit_ff;
      div_num_in = div_num_ff;
      div_rem_in = div_rem_ff;
      div_den_in = div_den_ff;
      d_in       = d_ff;
      invd_in    = invd_ff;
      m_in       = m_ff;
      u_in       = u_ff;

      case (state_ff)
         pfv_pkg::S_IDLE: begin
            if (accept && req_func == pfv_pkg::FUNC_POSITION) begin
               pos_in[0] = req_coord_x;
               pos_in[1] = req_coord_y;
               pos_in[2] = req_coord_z;
               rep_in    = '{default: '0};
               clip_in   = 1'b0;
               k_in      = '0;
               n_in      = (act_ext < 7'(MAX_OBSTACLES)) ? CNT_W'(act_ext)
                                                        : CNT_W'(MAX_OBSTACLES);
            end
         end
         pfv_pkg::S_LOOP: begin
            idx_in = 2'd0;
            acc_in = '0;
         end
         pfv_pkg::S_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               diff_in[i] = pfv_pkg::sat32(66'(pos_ff[i]) - 66'(obs_rd_ff[i]));
            end
         end
         pfv_pkg::S_SQACC, pfv_pkg::S_VSQACC: begin
            acc_in = acc_ff + prod_ff[63:0];
            if (last_axis) begin
               sq_x_in   = acc_ff + prod_ff[63:0];
               sq_r_in   = '0;
               sq_bit_in = 64'(1) << 62;
               cnt_in    = '0;
               idx_in    = 2'd0;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         pfv_pkg::S_SQRT: begin
            if (sq_x_ff >= sq_rb) begin
               sq_x_in = sq_x_ff - sq_rb;
               sq_r_in = (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            cnt_in    = cnt_ff + 6'd1;
         end
         pfv_pkg::S_DIV: begin
            div_rem_in = rem_ge ? 32'(rem_sh - {1'b0, div_den_ff}) : rem_sh[31:0];
            div_num_in = {div_num_ff[62:0], rem_ge};
            cnt_in     = cnt_ff + 6'd1;
         end
         pfv_pkg::S_DCHK: begin
            d_in = sq_r_ff[31:0];
            if (!obs_near) begin
               k_in = k_ff + CNT_W'(1);
            end
         end
         pfv_pkg::S_INVR: invd_in = div_num_ff[31:0];
         pfv_pkg::S_M2: begin
            m_in   = quo_sat;
            idx_in = 2'd0;
         end
         pfv_pkg::S_U: begin
            // Truncation toward zero: divide the magnitude, then restore the sign.
            u_in = diff_ff[idx_ff][31] ? -$signed(div_num_ff[32:0])
                                       : $signed(div_num_ff[32:0]);
         end
         pfv_pkg::S_REPADD: begin
            rep_in[idx_ff] = pfv_pkg::sat32(66'(rep_ff[idx_ff]) + (prod_ff >>> FRAC_BITS));
            if (last_axis) begin
               k_in = k_ff + CNT_W'(1);
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         pfv_pkg::S_ATTADD: begin
            vel_in[idx_ff] = pfv_pkg::sat32(
               66'(pfv_pkg::sat32(prod_ff >>> FRAC_BITS)) + 66'(rep_ff[idx_ff]));
            idx_in = last_axis ? 2'd0 : idx_ff + 2'd1;
         end
         pfv_pkg::S_NCHK: begin
            clip_in = need_clip;
            idx_in  = 2'd0;
         end
         pfv_pkg::S_CLQ: begin
            vel_in[idx_ff] = vel_ff[idx_ff][31] ? -$signed(div_num_ff[31:0])
                                                : $signed(div_num_ff[31:0]);
            idx_in = idx_ff + 2'd1;
         end
         default: ;
      endcase

      if (div_load) begin
         div_num_in = div_num_load;
         div_den_in = div_den_load;
         div_rem_in = '0;
         cnt_in     = '0;
      end
   end

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfv_pkg::S_IDLE;
         ret_ff   <= pfv_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      idx_ff     <= idx_in;
      k_ff       <= k_in;
      n_ff       <= n_in;
      pos_ff     <= pos_in;
      diff_ff    <= diff_in;
      rep_ff     <= rep_in;
      vel_ff     <= vel_in;
      clip_ff    <= clip_in;
      acc_ff     <= acc_in;
      sq_x_ff    <= sq_x_in;
      sq_r_ff    <= sq_r_in;
      sq_bit_ff  <= sq_bit_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_den_ff <= div_den_in;
      d_ff       <= d_in;
      invd_ff    <= invd_in;
      m_ff       <= m_in;
      u_ff       <= u_in;
      prod_ff    <= prod_in;
   end

   // Obstacle store: written by an accepted obstacle word whose slot exists,
   // read every cycle at the current obstacle index.
   always_ff @(posedge clock) begin
      if (accept && req_func == pfv_pkg::FUNC_OBSTACLE &&
          7'(req_obstacle_slot) < 7'(MAX_OBSTACLES)) begin
         obs_x_mem[IDX_W'(req_obstacle_slot)] <= req_coord_x;
         obs_y_mem[IDX_W'(req_obstacle_slot)] <= req_coord_y;
         obs_z_mem[IDX_W'(req_obstacle_slot)] <= req_coord_z;
      end
      obs_rd_ff[0] <= obs_x_mem[k_idx];
      obs_rd_ff[1] <= obs_y_mem[k_idx];
      obs_rd_ff[2] <= obs_z_mem[k_idx];
   end

   assign rsp_vel_x         = vel_ff[0];
   assign rsp_vel_y         = vel_ff[1];
   assign rsp_vel_z         = vel_ff[2];
   assign rsp_speed_clipped = clip_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `PFV_ASSERT_SAME(a_strobe_busy, clock, reset, rsp_valid, busy, "result strobe while idle")
   `PFV_ASSERT_NEXT(a_strobe_once, clock, reset, rsp_valid, !rsp_valid && !busy, "strobe not single")
   `PFV_ASSERT_NEXT(a_pos_busy, clock, reset, accept && req_func == pfv_pkg::FUNC_POSITION, busy, "position word not taken up")
   `PFV_ASSERT_SAME(a_div_den, clock, reset, state_ff == pfv_pkg::S_DIV, div_den_ff != '0, "division by zero")

endmodule
